// ===== design/jtl_pkg.sv =====
`timescale 1ns / 1ps
package jtl_pkg;

  localparam int PositionBitsDefault = 32;

  localparam int KindW  = 4;
  localparam int CharW  = 8;
  localparam int IntW   = 64;
  localparam int ErrW   = 4;
  localparam int PosOutW = 32;

  // Output queue: two entries per byte at most, plus room for the pending ones.
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [KindW-1:0] TK_LCB      = 4'd0;
  localparam logic [KindW-1:0] TK_RCB      = 4'd1;
  localparam logic [KindW-1:0] TK_LB       = 4'd2;
  localparam logic [KindW-1:0] TK_RB       = 4'd3;
  localparam logic [KindW-1:0] TK_COLON    = 4'd4;
  localparam logic [KindW-1:0] TK_COMMA    = 4'd5;
  localparam logic [KindW-1:0] TK_NULL     = 4'd6;
  localparam logic [KindW-1:0] TK_INTEGER  = 4'd9;
  localparam logic [KindW-1:0] TK_REAL     = 4'd10;
  localparam logic [KindW-1:0] TK_STR_BYTE = 4'd11;
  localparam logic [KindW-1:0] TK_STR_END  = 4'd12;
  localparam logic [KindW-1:0] TK_EOF      = 4'd13;
  localparam logic [KindW-1:0] TK_ERROR    = 4'd14;

  localparam logic [ErrW-1:0] ERR_NONE       = 4'd0;
  localparam logic [ErrW-1:0] ERR_UNEXPECTED = 4'd1;
  localparam logic [ErrW-1:0] ERR_KEYWORD    = 4'd2;
  localparam logic [ErrW-1:0] ERR_NO_POINT   = 4'd3;
  localparam logic [ErrW-1:0] ERR_NO_FRAC    = 4'd4;
  localparam logic [ErrW-1:0] ERR_NO_EXP     = 4'd5;
  localparam logic [ErrW-1:0] ERR_ESCAPE     = 4'd6;
  localparam logic [ErrW-1:0] ERR_OVERFLOW   = 4'd7;
  localparam logic [ErrW-1:0] ERR_EARLY_END  = 4'd8;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CharW-1:0] chr;
    logic [IntW-1:0]  ival;
    logic [ErrW-1:0]  err;
  } tok_t;

  typedef struct packed {
    logic               last;
    logic [PosOutW-1:0] column;
    logic [PosOutW-1:0] row;
    logic [ErrW-1:0]    err;
    logic [IntW-1:0]    ival;
    logic [CharW-1:0]   chr;
    logic [KindW-1:0]   kind;
  } result_t;

  // Keyword letters: k selects null, true or false.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: begin
        case (pos)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    return (k == 2'd2) ? 3'd5 : 3'd4;
  endfunction

endpackage

// ===== design/json_token_lexer_top.sv =====
`timescale 1ns / 1ps
// JSON lexer: one text byte per beat in, one token per beat out.
// The tokens of a byte are written into the output queue when the byte is taken.
// Throughput: one byte per cycle while each byte yields at most one token and the output
// is not held back; a byte that yields two tokens fills two entries of a four-entry queue.
// Reset: asynchronous, active low; lexer idle, row and column zero, queue empty.
module json_token_lexer_top
  import jtl_pkg::*;
#(
  parameter int POSITION_BITS = PositionBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] text_byte
  input  logic         s_axis_tuser_i,   // [0] end_of_input
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [7:0] char_value, [71:8] int_value, [75:72] error_code, [107:76] row,
  // [139:108] column
  output logic [143:0] m_axis_tdata_o,
  output logic [3:0]   m_axis_tuser_o,   // [3:0] token_kind
  output logic         m_axis_tlast_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_KW_NULL  = 4'd1;
  localparam logic [3:0] ST_KW_TRUE  = 4'd2;
  localparam logic [3:0] ST_KW_FALSE = 4'd3;
  localparam logic [3:0] ST_SIGN     = 4'd4;
  localparam logic [3:0] ST_ZERO     = 4'd5;
  localparam logic [3:0] ST_INT      = 4'd6;
  localparam logic [3:0] ST_DOT      = 4'd7;
  localparam logic [3:0] ST_FRAC     = 4'd8;
  localparam logic [3:0] ST_EXP      = 4'd9;
  localparam logic [3:0] ST_EXP_SIGN = 4'd10;
  localparam logic [3:0] ST_EXP_DIG  = 4'd11;
  localparam logic [3:0] ST_STR      = 4'd12;
  localparam logic [3:0] ST_STR_ESC  = 4'd13;

  localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MaxNeg = 64'h8000_0000_0000_0000;

  logic [3:0]               state_q, state_d;
  logic [POSITION_BITS-1:0] row_q, row_d, col_q, col_d;
  logic [63:0]              acc_q, acc_d;
  logic                     neg_q, neg_d;
  logic                     ovf_q, ovf_d;
  logic                     exp_dig_q, exp_dig_d;
  logic [2:0]               kw_pos_q, kw_pos_d;

  logic       in_beat, out_beat;
  logic [7:0] c;
  logic       c_digit;
  logic [3:0] digit;
  logic [67:0] scaled;
  logic [63:0] limit;
  logic [1:0]  kw_sel;

  tok_t fin_tok, main_tok, num_tok;
  logic fin_v, main_v, do_idle;

  result_t                slot0, slot1;
  logic [1:0]             n_res;
  logic [63:0]            row_ext, col_ext;

  result_t                queue_q [QueueDepth];
  logic [QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]       count_q;

  assign in_beat  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o & m_axis_tready_i;
  assign s_axis_tready_o = (count_q <= QCntW'(QueueDepth - 2));

  assign c       = s_axis_tdata_i;
  assign c_digit = c inside {["0":"9"]};
  assign digit   = c[3:0];
  // acc * 10 + digit as shifts; compared against the signed limit for overflow.
  assign scaled  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, digit};
  assign limit   = neg_q ? MaxNeg : MaxPos;
  assign kw_sel  = 2'(state_q - ST_KW_NULL);

  // Token for a number that ends here, taken from the state before this byte.
  always_comb begin
    num_tok = '0;
    if (state_q == ST_INT) begin
      if (ovf_q) begin
        num_tok.kind = TK_ERROR;
        num_tok.err  = ERR_OVERFLOW;
      end else begin
        num_tok.kind = TK_INTEGER;
        num_tok.ival = neg_q ? (64'd0 - acc_q) : acc_q;
      end
    end else if (state_q == ST_EXP_DIG && !exp_dig_q) begin
      num_tok.kind = TK_ERROR;
      num_tok.err  = ERR_NO_EXP;
    end else begin
      num_tok.kind = TK_REAL;
    end
  end

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    ovf_d     = ovf_q;
    exp_dig_d = exp_dig_q;
    kw_pos_d  = kw_pos_q;
    fin_v     = 1'b0;
    fin_tok   = '0;
    main_v    = 1'b0;
    main_tok  = '0;
    do_idle   = 1'b0;

    if (s_axis_tuser_i) begin
      if (state_q == ST_INT || state_q == ST_FRAC || state_q == ST_EXP_DIG) begin
        fin_v   = 1'b1;
        fin_tok = num_tok;
      end else if (state_q != ST_IDLE) begin
        fin_v       = 1'b1;
        fin_tok.kind = TK_ERROR;
        fin_tok.err  = ERR_EARLY_END;
      end
      state_d       = ST_IDLE;
      kw_pos_d      = 3'd0;
      main_v        = 1'b1;
      main_tok.kind = TK_EOF;
    end else begin
      if (c == 8'h0A) begin
        row_d = row_q + 1'b1;
        col_d = '0;
      end else begin
        col_d = col_q + 1'b1;
      end

      case (state_q)
        ST_KW_NULL, ST_KW_TRUE, ST_KW_FALSE: begin
          if (c != kw_char(kw_sel, kw_pos_q)) begin
            main_v        = 1'b1;
            main_tok.kind = TK_ERROR;
            main_tok.err  = ERR_KEYWORD;
            state_d       = ST_IDLE;
          end else if (kw_pos_q + 3'd1 == kw_len(kw_sel)) begin
            main_v        = 1'b1;
            main_tok.kind = TK_NULL + {2'b00, kw_sel};
            state_d       = ST_IDLE;
            kw_pos_d      = 3'd0;
          end else begin
            kw_pos_d = kw_pos_q + 3'd1;
          end
        end
        ST_SIGN, ST_INT: begin
          if (c_digit && !(state_q == ST_SIGN && c == "0")) begin
            if (!ovf_q) begin
              if (scaled > {4'd0, limit}) begin
                ovf_d = 1'b1;
              end else begin
                acc_d = scaled[63:0];
              end
            end
            state_d = ST_INT;
          end else if (state_q == ST_SIGN) begin
            if (c == "0") begin
              state_d = ST_ZERO;
            end else begin
              main_v        = 1'b1;
              main_tok.kind = TK_ERROR;
              main_tok.err  = ERR_UNEXPECTED;
              state_d       = ST_IDLE;
            end
          end else if (c == ".") begin
            state_d = ST_DOT;
          end else if (c == "e" || c == "E") begin
            state_d = ST_EXP;
          end else begin
            fin_v   = 1'b1;
            fin_tok = num_tok;
            do_idle = 1'b1;
          end
        end
        ST_ZERO: begin
          if (c == ".") begin
            state_d = ST_DOT;
          end else begin
            main_v        = 1'b1;
            main_tok.kind = TK_ERROR;
            main_tok.err  = ERR_NO_POINT;
            state_d       = ST_IDLE;
          end
        end
        ST_DOT: begin
          if (c_digit) begin
            state_d = ST_FRAC;
          end else begin
            main_v        = 1'b1;
            main_tok.kind = TK_ERROR;
            main_tok.err  = ERR_NO_FRAC;
            state_d       = ST_IDLE;
          end
        end
        ST_FRAC: begin
          if (c_digit) begin
            state_d = ST_FRAC;
          end else if (c == "e" || c == "E") begin
            state_d = ST_EXP;
          end else begin
            fin_v   = 1'b1;
            fin_tok = num_tok;
            do_idle = 1'b1;
          end
        end
        ST_EXP, ST_EXP_SIGN: begin
          if (state_q == ST_EXP && (c == "+" || c == "-")) begin
            state_d = ST_EXP_SIGN;
          end else if (c_digit) begin
            exp_dig_d = (c != "0");
            state_d   = ST_EXP_DIG;
          end else begin
            main_v        = 1'b1;
            main_tok.kind = TK_ERROR;
            main_tok.err  = ERR_UNEXPECTED;
            state_d       = ST_IDLE;
          end
        end
        ST_EXP_DIG: begin
          if (c_digit) begin
            if (c != "0") begin
              exp_dig_d = 1'b1;
            end
          end else begin
            fin_v   = 1'b1;
            fin_tok = num_tok;
            do_idle = 1'b1;
          end
        end
        ST_STR: begin
          if (c == "\\") begin
            state_d = ST_STR_ESC;
          end else if (c == "\"") begin
            main_v        = 1'b1;
            main_tok.kind = TK_STR_END;
            state_d       = ST_IDLE;
          end else begin
            main_v        = 1'b1;
            main_tok.kind = TK_STR_BYTE;
            main_tok.chr  = c;
          end
        end
        ST_STR_ESC: begin
          main_v        = 1'b1;
          main_tok.kind = TK_STR_BYTE;
          state_d       = ST_STR;
          case (c)
            "\"":    main_tok.chr = 8'h22;
            "\\":    main_tok.chr = 8'h5C;
            "/":     main_tok.chr = 8'h2F;
            "b":     main_tok.chr = 8'h08;
            "f":     main_tok.chr = 8'h0C;
            "n":     main_tok.chr = 8'h0A;
            "r":     main_tok.chr = 8'h0D;
            "t":     main_tok.chr = 8'h09;
            default: begin
              main_tok.kind = TK_ERROR;
              main_tok.err  = ERR_ESCAPE;
              state_d       = ST_IDLE;
            end
          endcase
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // Between tokens; also the byte that closed a number is handled here again.
      if (do_idle) begin
        state_d = ST_IDLE;
        case (c)
          8'h20, 8'h09, 8'h0D, 8'h0A: begin
          end
          "{": begin
            main_v        = 1'b1;
            main_tok.kind = TK_LCB;
          end
          "}": begin
            main_v        = 1'b1;
            main_tok.kind = TK_RCB;
          end
          "[": begin
            main_v        = 1'b1;
            main_tok.kind = TK_LB;
          end
          "]": begin
            main_v        = 1'b1;
            main_tok.kind = TK_RB;
          end
          ":": begin
            main_v        = 1'b1;
            main_tok.kind = TK_COLON;
          end
          ",": begin
            main_v        = 1'b1;
            main_tok.kind = TK_COMMA;
          end
          "n": begin
            state_d  = ST_KW_NULL;
            kw_pos_d = 3'd1;
          end
          "t": begin
            state_d  = ST_KW_TRUE;
            kw_pos_d = 3'd1;
          end
          "f": begin
            state_d  = ST_KW_FALSE;
            kw_pos_d = 3'd1;
          end
          "\"": begin
            state_d = ST_STR;
          end
          "-": begin
            acc_d     = '0;
            neg_d     = 1'b1;
            ovf_d     = 1'b0;
            exp_dig_d = 1'b0;
            state_d   = ST_SIGN;
          end
          default: begin
            if (c_digit) begin
              acc_d     = {60'd0, digit};
              neg_d     = 1'b0;
              ovf_d     = 1'b0;
              exp_dig_d = 1'b0;
              state_d   = (c == "0") ? ST_ZERO : ST_INT;
            end else begin
              main_v        = 1'b1;
              main_tok.kind = TK_ERROR;
              main_tok.err  = ERR_UNEXPECTED;
            end
          end
        endcase
      end
    end
  end

  // Both tokens of a byte report the position after that byte.
  assign row_ext = 64'(row_d);
  assign col_ext = 64'(col_d);
  assign n_res   = {1'b0, fin_v} + {1'b0, main_v};

  always_comb begin
    slot0        = '0;
    slot1        = '0;
    slot0.row    = row_ext[PosOutW-1:0];
    slot0.column = col_ext[PosOutW-1:0];
    slot1.row    = row_ext[PosOutW-1:0];
    slot1.column = col_ext[PosOutW-1:0];
    if (fin_v) begin
      slot0.kind = fin_tok.kind;
      slot0.chr  = fin_tok.chr;
      slot0.ival = fin_tok.ival;
      slot0.err  = fin_tok.err;
      slot0.last = !main_v;
      slot1.kind = main_tok.kind;
      slot1.chr  = main_tok.chr;
      slot1.ival = main_tok.ival;
      slot1.err  = main_tok.err;
      slot1.last = 1'b1;
    end else begin
      slot0.kind = main_tok.kind;
      slot0.chr  = main_tok.chr;
      slot0.ival = main_tok.ival;
      slot0.err  = main_tok.err;
      slot0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      ovf_q     <= 1'b0;
      exp_dig_q <= 1'b0;
      kw_pos_q  <= 3'd0;
    end else if (in_beat) begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      ovf_q     <= ovf_d;
      exp_dig_q <= exp_dig_d;
      kw_pos_q  <= kw_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= slot0;
    end
    if (in_beat && n_res == 2'd2) begin
      queue_q[wr_ptr_q + 1'b1] <= slot1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_beat) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(n_res);
      end
      if (out_beat) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (in_beat ? QCntW'(n_res) : '0) - QCntW'(out_beat);
    end
  end

  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = {4'd0, queue_q[rd_ptr_q].column, queue_q[rd_ptr_q].row,
                            queue_q[rd_ptr_q].err, queue_q[rd_ptr_q].ival,
                            queue_q[rd_ptr_q].chr};
  assign m_axis_tuser_o  = queue_q[rd_ptr_q].kind;
  assign m_axis_tlast_o  = queue_q[rd_ptr_q].last;

endmodule
